// ===== rtl/core/life_like_automaton_step_core_macros.svh =====
// Assertion macros shared by the automaton step core.
// Expects signals clk and arst_n in the scope of each use.
`ifndef LIFE_LIKE_AUTOMATON_STEP_CORE_MACROS_SVH
`define LIFE_LIKE_AUTOMATON_STEP_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define LLA_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define LLA_ASSERT_NEXT(name, trig, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== rtl/core/lla_step_pkg.sv =====
// Package for the automaton step core: item kinds, register indexes,
// reset values and the structs passed between the core's modules.
package lla_step_pkg;

	localparam int CFG_DW = 11;
	localparam int MASK_W = 9;
	localparam int GRID_RST = 64;
	localparam logic [MASK_W-1:0] BORN_RST = 9'd8;
	localparam logic [MASK_W-1:0] SURV_RST = 9'd12;

	typedef enum logic {
		CMD_CELL  = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_GRID_WIDTH   = 2'd0,
		REG_GRID_HEIGHT  = 2'd1,
		REG_BORN_MASK    = 2'd2,
		REG_SURVIVE_MASK = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_FILL,
		KIND_CELL,
		KIND_FLUSH
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  border;
		logic  done;
		logic  last_row;
	} tag_t;

	typedef struct packed {
		logic [MASK_W-1:0] born;
		logic [MASK_W-1:0] survive;
	} rule_cfg_t;

	typedef struct packed {
		logic alive;
		logic valid;
		logic done;
	} result_t;

endpackage

// ===== rtl/core/life_like_automaton_step_core.sv =====
// Top level of the life-like automaton step core: stream ports, pipeline
// registers and output register. Depends on lla_step_pkg and the ctrl,
// lines and rule modules, and on the assertion macro header.
//
// One generation of a binary Moore-neighbourhood automaton over a raster
// cell stream. Every accepted item (a cell, or a flush) gives exactly one
// result transfer; items are taken one per cycle while the output is not
// stalled and no clear runs, and each result reaches the output register
// through stage 1, with line-store read data registered in between.
// Results of a cell lag its position by one row plus one cell; flushes at
// the start of the next frame drain the rest. After reset the line stores
// are swept to zero, during which s_tready stays low; configuration writes
// are taken at all times and must only be issued while the core is idle.
`include "life_like_automaton_step_core_macros.svh"

module life_like_automaton_step_core
	import lla_step_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [0] cell_in, [7:1] zero
	input  logic              s_tuser,   // [0] cmd
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [0] cell_out, [7:1] zero
	output logic              m_tuser,   // [0] out_valid
	output logic              m_tlast
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic          in_fire;
	logic          adv1;
	logic          clr_busy;
	tag_t          tag;
	logic [CW-1:0] addr;
	rule_cfg_t     rule;
	logic [1:0]    rd_data;
	result_t       res;

	logic          s1_v_q;
	tag_t          tag_s1;
	logic          cell_s1;
	logic [CW-1:0] col_s1;
	logic          o_v_q;
	logic          o_cell_q;
	logic          o_valid_q;
	logic          o_done_q;
	logic          wr_en;

	assign adv1 = s1_v_q && (!o_v_q || m_tready);
	assign s_tready = !clr_busy && (!s1_v_q || adv1);
	assign in_fire = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign wr_en = adv1 && ((tag_s1.kind == KIND_CELL) || (tag_s1.kind == KIND_FILL));

	lla_step_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (in_fire),
		.cmd      (s_tuser),
		.tag      (tag),
		.addr     (addr),
		.rule     (rule)
	);

	lla_step_lines #(
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_fire),
		.rd_addr(addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(col_s1),
		.wr_data({cell_s1, rd_data[1]}),
		.busy   (clr_busy)
	);

	lla_step_rule u_rule (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv1),
		.tag     (tag_s1),
		.cell_new(cell_s1),
		.rd      (rd_data),
		.rule    (rule),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			o_v_q <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_v_q <= 1'b1;
			end else if (adv1) begin
				s1_v_q <= 1'b0;
			end
			if (adv1) begin
				o_v_q <= 1'b1;
			end else if (m_tready) begin
				o_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			tag_s1 <= tag;
			cell_s1 <= s_tdata[0];
			col_s1 <= addr;
		end
		if (adv1) begin
			o_cell_q <= res.alive;
			o_valid_q <= res.valid;
			o_done_q <= res.done;
		end
	end

	assign m_tvalid = o_v_q;
	assign m_tdata = {7'd0, o_cell_q};
	assign m_tuser = o_valid_q;
	assign m_tlast = o_done_q;

	`LLA_ASSERT_ALWAYS(a_no_take_in_clear, !(clr_busy && s_tready), "item taken during clear")
	`LLA_ASSERT_NEXT(a_s1_hold, s1_v_q && o_v_q && !m_tready, s1_v_q && $stable(tag_s1),
		"stage 1 lost while output stalled")
	`LLA_ASSERT_NEXT(a_fill_quiet,
		adv1 && ((tag_s1.kind == KIND_FILL) || (tag_s1.kind == KIND_NONE)),
		!o_valid_q && !o_done_q, "result flagged for an item without one")
	`LLA_ASSERT_ALWAYS(a_done_valid, !o_v_q || !o_done_q || o_valid_q,
		"frame end on a non-result")

endmodule

// ===== rtl/core/lla_step_ctrl.sv =====
// Configuration registers and raster position tracking of the step core.
// Depends on lla_step_pkg.
module lla_step_ctrl
	import lla_step_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [1:0]                   cfg_index,
	input  logic [CFG_DW-1:0]            cfg_data,
	input  logic                         accept,
	input  logic                         cmd,
	output tag_t                         tag,
	output logic [$clog2(MAX_WIDTH)-1:0] addr,
	output rule_cfg_t                    rule
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);
	localparam int W_RST = (GRID_RST > MAX_WIDTH) ? MAX_WIDTH : GRID_RST;
	localparam int H_RST = (GRID_RST > MAX_HEIGHT) ? MAX_HEIGHT : GRID_RST;

	logic [WW-1:0]     w_q;
	logic [HW-1:0]     h_q;
	logic [MASK_W-1:0] born_q;
	logic [MASK_W-1:0] surv_q;
	logic [CW-1:0]     in_col_q;
	logic [RW-1:0]     in_row_q;
	logic [CW-1:0]     out_col_q;
	logic [RW-1:0]     out_row_q;
	logic [PW-1:0]     pend_q;

	logic [WW-1:0] w1;
	logic [HW-1:0] h1;
	logic [PW-1:0] full;
	logic          at_start;
	logic          restart;
	logic [CW-1:0] oc;
	logic [RW-1:0] orow;
	logic          o_last_col;
	logic          o_last_row;
	logic [CW-1:0] oc_adv;
	logic [RW-1:0] orow_adv;
	logic [CW-1:0] in_col_nx;
	logic [RW-1:0] in_row_nx;
	logic [CW-1:0] out_col_nx;
	logic [RW-1:0] out_row_nx;
	logic [PW-1:0] pend_nx;
	logic [PW-1:0] pend_base;

	always_comb begin
		w1 = w_q - WW'(1);
		h1 = h_q - HW'(1);
		full = PW'(w_q) + PW'(1);
		at_start = (in_col_q == '0) && (in_row_q == '0);
		restart = (cmd == CMD_CELL) && at_start && (pend_q != full);
		oc = restart ? '0 : out_col_q;
		orow = restart ? '0 : out_row_q;
		pend_base = restart ? '0 : pend_q;
		o_last_col = (WW'(oc) == w1);
		o_last_row = (HW'(orow) == h1);
		oc_adv = o_last_col ? '0 : oc + CW'(1);
		orow_adv = o_last_col ? (o_last_row ? '0 : orow + RW'(1)) : orow;

		tag = '{kind: KIND_NONE, border: 1'b0, done: 1'b0, last_row: 1'b0};
		addr = in_col_q;
		in_col_nx = in_col_q;
		in_row_nx = in_row_q;
		out_col_nx = oc;
		out_row_nx = orow;
		pend_nx = pend_base;

		if (cmd == CMD_CELL) begin
			if (WW'(in_col_q) == w1) begin
				in_col_nx = '0;
				in_row_nx = (HW'(in_row_q) == h1) ? '0 : in_row_q + RW'(1);
			end else begin
				in_col_nx = in_col_q + CW'(1);
			end
			if (pend_base < full) begin
				tag.kind = KIND_FILL;
				pend_nx = pend_base + PW'(1);
			end else begin
				tag.kind = KIND_CELL;
				tag.border = (orow == '0) || o_last_row || (oc == '0) || o_last_col;
				tag.done = o_last_row && o_last_col;
				out_col_nx = oc_adv;
				out_row_nx = orow_adv;
			end
		end else if (at_start && (pend_q != '0)) begin
			tag.kind = KIND_FLUSH;
			tag.last_row = o_last_row;
			tag.done = o_last_row && o_last_col;
			addr = oc;
			pend_nx = pend_q - PW'(1);
			out_col_nx = oc_adv;
			out_row_nx = orow_adv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			h_q <= HW'(H_RST);
			born_q <= BORN_RST;
			surv_q <= SURV_RST;
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GRID_WIDTH: begin
					if (cfg_data < CFG_DW'(3)) begin
						w_q <= WW'(3);
					end else if (32'(cfg_data) > MAX_WIDTH) begin
						w_q <= WW'(MAX_WIDTH);
					end else begin
						w_q <= WW'(cfg_data);
					end
					in_col_q <= '0;
					in_row_q <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
					pend_q <= '0;
				end
				REG_GRID_HEIGHT: begin
					if (cfg_data < CFG_DW'(3)) begin
						h_q <= HW'(3);
					end else if (32'(cfg_data) > MAX_HEIGHT) begin
						h_q <= HW'(MAX_HEIGHT);
					end else begin
						h_q <= HW'(cfg_data);
					end
					in_col_q <= '0;
					in_row_q <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
					pend_q <= '0;
				end
				REG_BORN_MASK: begin
					born_q <= cfg_data[MASK_W-1:0];
				end
				REG_SURVIVE_MASK: begin
					surv_q <= cfg_data[MASK_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			in_col_q <= in_col_nx;
			in_row_q <= in_row_nx;
			out_col_q <= out_col_nx;
			out_row_q <= out_row_nx;
			pend_q <= pend_nx;
		end
	end

	assign rule = '{born: born_q, survive: surv_q};

endmodule

// ===== rtl/core/lla_step_lines.sv =====
// Two-row line store, one bit per row per column, with registered read,
// write-to-read forwarding and a clearing sweep after reset.
module lla_step_lines #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [1:0]               rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [1:0]               wr_data,
	output logic                     busy
);

	localparam int AW = $clog2(DEPTH);

	logic [1:0]    mem [DEPTH];
	logic [1:0]    rd_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_busy_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [1:0]    wd;

	always_comb begin
		we = clr_busy_q || wr_en;
		wa = clr_busy_q ? clr_addr_q : wr_addr;
		wd = clr_busy_q ? 2'b00 : wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			if (we && (wa == rd_addr)) begin
				rd_q <= wd;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;
	assign busy = clr_busy_q;

endmodule

// ===== rtl/core/lla_step_rule.sv =====
// 3x3 window register and the neighbour count and mask rule.
// Depends on lla_step_pkg.
module lla_step_rule
	import lla_step_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  tag_t      tag,
	input  logic      cell_new,
	input  logic [1:0] rd,
	input  rule_cfg_t rule,
	output result_t   res
);

	logic [8:0] win_q;
	logic [8:0] win_nx;
	logic [8:0] nbr;
	logic [3:0] cnt;
	logic       center;
	logic       shift;

	always_comb begin
		shift = (tag.kind == KIND_CELL) || (tag.kind == KIND_FILL);
		win_nx = {cell_new, rd[1], rd[0], win_q[8:3]};
		center = win_nx[4];
		nbr = win_nx & 9'h1EF;
		cnt = '0;
		for (int i = 0; i < 9; i++) begin
			cnt = cnt + 4'(nbr[i]);
		end
		res = '{alive: 1'b0, valid: 1'b0, done: 1'b0};
		unique case (tag.kind)
			KIND_CELL: begin
				res.valid = 1'b1;
				res.done = tag.done;
				if (tag.border) begin
					res.alive = center;
				end else begin
					res.alive = center ? rule.survive[cnt] : rule.born[cnt];
				end
			end
			KIND_FLUSH: begin
				res.valid = 1'b1;
				res.done = tag.done;
				res.alive = tag.last_row ? rd[1] : rd[0];
			end
			KIND_NONE, KIND_FILL: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (step && shift) begin
			win_q <= win_nx;
		end
	end

endmodule

// ===== bench/life_like_automaton_step_core_test.sv =====
// Testbench of the life-like automaton step core: streams raster grids,
// flushes and register writes, predicts every result transfer and checks it.
// Depends on lla_step_pkg and the RTL of life_like_automaton_step_core.
module life_like_automaton_step_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lla_step_pkg::*;

	localparam int GRID_MAX = 1024;

	typedef struct {
		cmd_t cmd;
		logic alive;
		bit   drain_first;
	} grid_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	reg_idx_t          cfg_index = REG_GRID_WIDTH;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;
	logic              m_tuser;
	logic              m_tlast;

	life_like_automaton_step_core dut (.*);

	always #5 clk = ~clk;

	// next-generation predictor state
	logic [CFG_DW-1:0] grid_w_reg = CFG_DW'(GRID_RST);
	logic [CFG_DW-1:0] grid_h_reg = CFG_DW'(GRID_RST);
	rule_cfg_t         rules = '{born: BORN_RST, survive: SURV_RST};
	logic              line_near [GRID_MAX] = '{default: 1'b0};
	logic              line_far [GRID_MAX] = '{default: 1'b0};
	logic [8:0]        window = '0;
	int unsigned       in_col = 0, in_row = 0, out_col = 0, out_row = 0, unanswered = 0;

	grid_item_t  stream_q[$];
	result_t     next_gen_q[$];
	grid_item_t  next_item;
	result_t     want;
	logic        item_taken = 1'b0;
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatches = 0;

	function automatic int unsigned clamp_dim(input logic [CFG_DW-1:0] v);
		if (v < 3)
			return 3;
		if (v > GRID_MAX)
			return GRID_MAX;
		return 32'(v);
	endfunction

	function automatic void restart_positions();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		unanswered = 0;
	endfunction

	function automatic logic advance_out(input int unsigned w, input int unsigned h);
		logic last;
		last = (out_row + 1 >= h) && (out_col + 1 >= w);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h)
				out_row = 0;
		end
		return last;
	endfunction

	function automatic result_t step_generation(input cmd_t cmd, input logic alive);
		int unsigned w, h, col;
		logic        far_b, near_b, centre, at_start, on_border;
		logic [8:0]  mask;
		result_t     r;
		w = clamp_dim(grid_w_reg);
		h = clamp_dim(grid_h_reg);
		r = '0;
		at_start = (in_row == 0) && (in_col == 0);
		if (cmd == CMD_CELL) begin
			if (at_start && unanswered != w + 1) begin
				unanswered = 0;
				out_row = 0;
				out_col = 0;
			end
			col = (in_col < GRID_MAX) ? in_col : 0;
			far_b = line_far[col];
			near_b = line_near[col];
			line_far[col] = near_b;
			line_near[col] = alive;
			window = {alive, near_b, far_b, window[8:3]};
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h)
					in_row = 0;
			end
			if (unanswered < w + 1) begin
				unanswered++;
			end else begin
				centre = window[4];
				on_border = (out_row == 0) || (out_row + 1 >= h) ||
					(out_col == 0) || (out_col + 1 >= w);
				if (on_border) begin
					r.alive = centre;
				end else begin
					mask = centre ? rules.survive : rules.born;
					r.alive = mask[$countones(window & 9'h1EF)];
				end
				r.valid = 1'b1;
				r.done = advance_out(w, h);
			end
		end else if (at_start && unanswered > 0) begin
			col = (out_col < GRID_MAX) ? out_col : 0;
			r.alive = (out_row + 1 >= h) ? line_near[col] : line_far[col];
			r.valid = 1'b1;
			unanswered--;
			r.done = advance_out(w, h);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_GRID_WIDTH: begin
				grid_w_reg = value;
				restart_positions();
			end
			REG_GRID_HEIGHT: begin
				grid_h_reg = value;
				restart_positions();
			end
			REG_BORN_MASK: rules.born = value[MASK_W-1:0];
			REG_SURVIVE_MASK: rules.survive = value[MASK_W-1:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (stream_q.size() != 0 || s_tvalid || next_gen_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic void push_item(input cmd_t cmd, input logic alive, input bit drain_first);
		grid_item_t it;
		it.cmd = cmd;
		it.alive = alive;
		it.drain_first = drain_first;
		stream_q.push_back(it);
	endfunction

	function automatic void queue_cells(input int unsigned count);
		int unsigned pct;
		pct = $urandom_range(3);
		pct = (pct == 0) ? 0 : (pct == 1) ? 100 : $urandom_range(10, 90);
		for (int unsigned i = 0; i < count; i++) begin
			push_item(CMD_CELL, $urandom_range(99) < pct, $urandom_range(99) < 2);
			if (i + 1 < count && $urandom_range(99) < 3)
				push_item(CMD_FLUSH, 1'($urandom_range(1)), 1'b0);
		end
	endfunction

	function automatic void queue_flushes(input int unsigned count);
		repeat (count)
			push_item(CMD_FLUSH, 1'($urandom_range(1)), 1'b0);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (next_gen_q.size() == 0) begin
					report_mismatch($sformatf("result with none expected, tdata %h", m_tdata));
				end else begin
					want = next_gen_q.pop_front();
					if (m_tdata !== {7'b0, want.alive})
						report_mismatch($sformatf("cell_out got %h want %0d", m_tdata, want.alive));
					if (m_tuser !== want.valid)
						report_mismatch($sformatf("out_valid got %b want %b", m_tuser, want.valid));
					if (m_tlast !== want.done)
						report_mismatch($sformatf("frame_done got %b want %b", m_tlast, want.done));
				end
			end
			if (s_tvalid && s_tready)
				next_gen_q.push_back(step_generation(cmd_t'(s_tuser), s_tdata[0]));
			item_taken <= s_tvalid && s_tready;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || item_taken) begin
				if (stream_q.size() != 0 && !(stream_q[0].drain_first && next_gen_q.size() != 0)
						&& $urandom_range(99) >= send_gap_pct) begin
					next_item = stream_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'b0, next_item.alive};
					s_tuser <= next_item.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= $urandom_range(99) >= stall_pct;
		end
	end

	initial begin
		logic [17:0] pattern;
		int unsigned w, h, queued, pick;
		logic [CFG_DW-1:0] w_raw, h_raw, born_v, surv_v;
		pattern = 18'b010_111_010_110_101_011;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// flush with nothing pending, then two 3x3 frames back to back
		push_item(CMD_FLUSH, 1'b1, 1'b0);
		wait_idle();
		write_reg(REG_GRID_WIDTH, 11'd0);
		write_reg(REG_GRID_HEIGHT, 11'd2);
		for (int i = 0; i < 18; i++) begin
			push_item(CMD_CELL, pattern[i], i == 13);
			if (i == 4)
				push_item(CMD_FLUSH, 1'b0, 1'b0);
		end
		queue_flushes(2);
		repeat (3)
			push_item(CMD_CELL, 1'b1, 1'b0);
		wait_idle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_gap_pct = 0; stall_pct = 0; end
				1: begin send_gap_pct = 72; stall_pct = 0; end
				2: begin send_gap_pct = 0; stall_pct = 72; end
				default: begin send_gap_pct = 31; stall_pct = 31; end
			endcase
			w_raw = (phase == 5) ? CFG_DW'($urandom_range(2)) : CFG_DW'($urandom_range(3, 9));
			h_raw = (phase == 6) ? CFG_DW'($urandom_range(2)) : CFG_DW'($urandom_range(3, 6));
			born_v = CFG_DW'($urandom_range(2047));
			surv_v = CFG_DW'($urandom_range(2047));
			if (phase == 1) begin
				born_v = '0;
				surv_v = '1;
			end else if (phase == 2) begin
				born_v = '1;
				surv_v = '0;
			end
			write_reg(REG_GRID_WIDTH, w_raw);
			write_reg(REG_GRID_HEIGHT, h_raw);
			write_reg(REG_BORN_MASK, born_v);
			write_reg(REG_SURVIVE_MASK, surv_v);
			w = clamp_dim(w_raw);
			h = clamp_dim(h_raw);
			queued = 0;
			while (queued < 40) begin
				queue_cells(w * h);
				queued += w * h;
				pick = $urandom_range(9);
				if (pick < 6)
					queue_flushes(w + 1);
				else if (pick >= 8)
					queue_flushes($urandom_range(1, w));
			end
			wait_idle();
		end

		// widest and tallest grids, partly fed
		send_gap_pct = 0;
		stall_pct = 0;
		write_reg(REG_GRID_WIDTH, '1);
		write_reg(REG_GRID_HEIGHT, '0);
		queue_cells(40);
		wait_idle();
		write_reg(REG_GRID_WIDTH, '0);
		write_reg(REG_GRID_HEIGHT, '1);
		queue_cells(40);
		wait_idle();

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

endmodule
